// ----- rtl/bounded_retry_pacer_assert.svh -----
// assertion macros used by the pacer rtl
`ifndef BOUNDED_RETRY_PACER_ASSERT_SVH
`define BOUNDED_RETRY_PACER_ASSERT_SVH

// property must hold in the same cycle, outside reset
`define BRP_ASSERT_NOW(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when trig holds, cond must hold in the next cycle, outside reset
`define BRP_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/brp_pkg.sv -----
// types and constants of the retry pacer
`default_nettype none

package brp_pkg;

  // width of time stamps in ticks
  localparam int TIME_BITS = 48;
  localparam int TRIES_BITS = 8;
  localparam int DELAY_BITS = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_INDEX_BITS = 1;

  // event kinds
  typedef enum logic [1:0] {
    CMD_REQUEST   = 2'd0,
    CMD_POLL      = 2'd1,
    CMD_SUCCEEDED = 2'd2,
    CMD_FAILED    = 2'd3
  } cmd_t;

  // poll answers
  typedef enum logic [1:0] {
    DEC_HOLD      = 2'd0,
    DEC_ATTEMPT   = 2'd1,
    DEC_EXHAUSTED = 2'd2,
    DEC_NONE      = 2'd3
  } decision_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_TRIES = 1'd0,
    REG_BACKOFF   = 1'd1
  } cfg_reg_t;

  localparam logic [TRIES_BITS-1:0] MAX_TRIES_RESET = TRIES_BITS'(3);
  localparam logic [DELAY_BITS-1:0] BACKOFF_RESET = DELAY_BITS'(1000);

  typedef struct packed {
    cmd_t                 cmd;
    logic [TIME_BITS-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    decision_t            decision;
    logic                 wake_valid;
    logic [TIME_BITS-1:0] wake_time;
    logic                 pending_flag;
    logic                 given_up_flag;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/bounded_retry_pacer.sv -----
// Retry pacer with attempt ceiling and fixed back-off between tries.
//
// Items arrive on the in channel (in_valid / in_stall / in_item): each is one
// event (request, poll, succeeded, failed) with a time stamp. Every item gives
// exactly one result item on the out channel (out_valid / out_stall /
// out_item): the poll decision, the next wake-up time and the flags.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data): index 0
// is the attempt ceiling, index 1 the retry delay in ticks.
// An item is captured in the input register, its result is computed in one
// pass and loaded into the result register. Throughput is one item per cycle
// while the receiver does not stall; the pass over the pacing state (one
// 48-bit compare, one saturating add) sets that figure. When the receiver
// stalls, the result register holds and the input register keeps one more
// item, after which in_stall rises. Reset clears both registers, the pacing
// state and returns the configuration to a ceiling of three tries and a
// delay of 1000 ticks.
`default_nettype none
`include "bounded_retry_pacer_assert.svh"

module bounded_retry_pacer
  import brp_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_we,
  input  wire [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire [CFG_DATA_BITS-1:0]  cfg_data,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire in_item_t            in_item,
  output logic                     out_valid,
  input  wire                      out_stall,
  output out_item_t                out_item
);

  localparam int SUM_BITS = ((TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // configuration registers
  logic [TRIES_BITS-1:0] max_tries;
  logic [DELAY_BITS-1:0] backoff;

  // pacing state
  logic                 pending;
  logic                 given_up;
  logic [TRIES_BITS-1:0] tries_used;
  logic [TIME_BITS-1:0] next_due_time;

  logic                 pending_next;
  logic                 given_up_next;
  logic [TRIES_BITS-1:0] tries_used_next;
  logic [TIME_BITS-1:0] next_due_time_next;

  // input register
  logic     item_q_valid;
  in_item_t item_q;

  logic                 advance;
  logic [SUM_BITS-1:0]  later_sum;
  logic [TIME_BITS-1:0] later_time;
  out_item_t            result_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_tries <= MAX_TRIES_RESET;
      backoff   <= BACKOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_TRIES: max_tries <= cfg_data[TRIES_BITS-1:0];
        REG_BACKOFF:   backoff <= cfg_data[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // the held item moves on when the result register is free or being emptied
  assign advance  = item_q_valid && (!out_valid || !out_stall);
  assign in_stall = item_q_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (!in_stall) begin
      item_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_q <= in_item;
    end
  end

  // saturating now plus delay
  always_comb begin
    later_sum = SUM_BITS'(item_q.now_time) + SUM_BITS'(backoff);
    if (later_sum > SUM_BITS'(TIME_MAX)) begin
      later_time = TIME_MAX;
    end else begin
      later_time = later_sum[TIME_BITS-1:0];
    end
  end

  // one event against the pacing state
  always_comb begin
    pending_next       = pending;
    given_up_next      = given_up;
    tries_used_next    = tries_used;
    next_due_time_next = next_due_time;
    result_next        = '0;
    result_next.decision = DEC_NONE;
    case (item_q.cmd)
      CMD_REQUEST: begin
        if (!given_up && !pending) begin
          pending_next       = 1'b1;
          next_due_time_next = item_q.now_time;
        end
      end
      CMD_POLL: begin
        if (!pending) begin
          result_next.decision = DEC_HOLD;
        end else if (tries_used >= max_tries) begin
          pending_next         = 1'b0;
          given_up_next        = 1'b1;
          result_next.decision = DEC_EXHAUSTED;
        end else if (item_q.now_time < next_due_time) begin
          result_next.decision = DEC_HOLD;
        end else begin
          tries_used_next      = tries_used + TRIES_BITS'(1);
          next_due_time_next   = later_time;
          result_next.decision = DEC_ATTEMPT;
        end
      end
      CMD_SUCCEEDED: begin
        pending_next    = 1'b0;
        tries_used_next = '0;
      end
      default: begin
        next_due_time_next = later_time;
      end
    endcase
    // wake-up time from the state this event leaves
    if (pending_next) begin
      result_next.wake_time = (tries_used_next >= max_tries) ? item_q.now_time
                                                             : next_due_time_next;
    end
    result_next.wake_valid    = pending_next;
    result_next.pending_flag  = pending_next;
    result_next.given_up_flag = given_up_next;
  end

  // pacing state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      given_up      <= 1'b0;
      tries_used    <= '0;
      next_due_time <= '0;
    end else if (advance) begin
      pending       <= pending_next;
      given_up      <= given_up_next;
      tries_used    <= tries_used_next;
      next_due_time <= next_due_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result_next;
    end
  end

  // checks
  `BRP_ASSERT_NOW(a_flags_exclusive, clk, rst, !(pending && given_up), "pending while given up")
  `BRP_ASSERT_NEXT(a_given_up_sticky, clk, rst, given_up, given_up, "given_up cleared")
  `BRP_ASSERT_NOW(a_wake_follows_pending, clk, rst,
    !out_valid || (out_item.wake_valid == out_item.pending_flag), "wake_valid mismatch")
  `BRP_ASSERT_NOW(a_attempt_keeps_pending, clk, rst,
    !out_valid || (out_item.decision != DEC_ATTEMPT) || out_item.pending_flag,
    "attempt without pending")

endmodule

`default_nettype wire

// ----- tb/bounded_retry_pacer_tb.sv -----
// self-checking testbench for the bounded retry pacer
`default_nettype none

module bounded_retry_pacer_tb
  import brp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TIME_BITS-1:0] TOP_TIME = '1;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  out_item_t                 out_item;

  bounded_retry_pacer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // clock
  always #1 clk = ~clk;

  // events waiting to be offered, outcomes waiting to be seen
  in_item_t  event_q[$];
  out_item_t outcome_q[$];

  // pacing state as the block should hold it
  logic                  armed = 1'b0;
  logic                  gave_up = 1'b0;
  logic [TRIES_BITS-1:0] tries = '0;
  logic [TIME_BITS-1:0]  due = '0;
  logic [TRIES_BITS-1:0] ceil_cfg = MAX_TRIES_RESET;
  logic [DELAY_BITS-1:0] delay_cfg = BACKOFF_RESET;

  int n_queued = 0;
  int n_outcomes = 0;
  int n_bad = 0;
  int n_hold = 0;
  int n_attempt = 0;
  int n_exhaust = 0;

  // stimulus time line, and the knobs for the pressure phases
  logic [TIME_BITS-1:0] t_cur = '0;
  logic                 calm = 1'b0;
  logic                 want_choke = 1'b0;
  logic                 choke_done = 1'b0;
  int                   choke_left = 0;

  // time plus the retry delay, saturating at the top of the time range
  function automatic logic [TIME_BITS-1:0] push_back_time(logic [TIME_BITS-1:0] t);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, t} + (TIME_BITS+1)'(delay_cfg);
    return sum[TIME_BITS] ? TOP_TIME : sum[TIME_BITS-1:0];
  endfunction

  // apply one event to the pacing state and queue the outcome it must give
  task automatic pace_event(in_item_t it);
    out_item_t o;
    o = '0;
    o.decision = DEC_NONE;
    case (it.cmd)
      CMD_REQUEST: begin
        if (!gave_up && !armed) begin
          armed = 1'b1;
          due = it.now_time;
        end
      end
      CMD_POLL: begin
        if (!armed) begin
          o.decision = DEC_HOLD;
        end else if (tries >= ceil_cfg) begin
          armed = 1'b0;
          gave_up = 1'b1;
          o.decision = DEC_EXHAUSTED;
        end else if (it.now_time < due) begin
          o.decision = DEC_HOLD;
        end else begin
          tries = tries + TRIES_BITS'(1);
          due = push_back_time(it.now_time);
          o.decision = DEC_ATTEMPT;
        end
      end
      CMD_SUCCEEDED: begin
        armed = 1'b0;
        tries = '0;
      end
      default: begin
        due = push_back_time(it.now_time);
      end
    endcase
    o.wake_valid = armed;
    o.wake_time = !armed ? '0 : (tries >= ceil_cfg) ? it.now_time : due;
    o.pending_flag = armed;
    o.given_up_flag = gave_up;
    case (o.decision)
      DEC_HOLD:      n_hold++;
      DEC_ATTEMPT:   n_attempt++;
      DEC_EXHAUSTED: n_exhaust++;
      default: ;
    endcase
    outcome_q.push_back(o);
  endtask

  // one field of an outcome against its expectation
  task automatic note_field(string fname, logic [TIME_BITS-1:0] want,
                            logic [TIME_BITS-1:0] got);
    if (want !== got) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch at %0t in %s: expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // compare a result item with the oldest outcome expected
  task automatic check_outcome(out_item_t got);
    out_item_t want;
    if (outcome_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("mismatch at %0t: result %p with nothing expected", $time, got);
    end else begin
      want = outcome_q.pop_front();
      n_outcomes++;
      note_field("decision", TIME_BITS'(want.decision), TIME_BITS'(got.decision));
      note_field("wake_valid", TIME_BITS'(want.wake_valid), TIME_BITS'(got.wake_valid));
      note_field("wake_time", want.wake_time, got.wake_time);
      note_field("pending_flag", TIME_BITS'(want.pending_flag),
                 TIME_BITS'(got.pending_flag));
      note_field("given_up_flag", TIME_BITS'(want.given_up_flag),
                 TIME_BITS'(got.given_up_flag));
    end
  endtask

  // sender: offers queued events, holds a stalled item, idles at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pace_event(in_item);
      end
      if (!in_valid || !in_stall) begin
        if (event_q.size() != 0 && (calm || $urandom_range(0, 99) >= 37)) begin
          in_item <= event_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results, stalls at random, and once holds off for long
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_outcome(out_item);
      end
      if (want_choke && !choke_done) begin
        choke_left = 120;
        choke_done = 1'b1;
      end
      if (choke_left > 0) begin
        choke_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 37);
      end
    end
  end

  task automatic queue_event(cmd_t c, logic [TIME_BITS-1:0] t);
    in_item_t it;
    it.cmd = c;
    it.now_time = t;
    event_q.push_back(it);
    n_queued++;
  endtask

  // move the time line on: mostly small steps or about one delay, at times a
  // big jump or a step backwards
  function automatic logic [TIME_BITS-1:0] step_time();
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] hop;
    int unsigned          r;
    r = $urandom_range(0, 99);
    if (r < 45)
      hop = TIME_BITS'($urandom_range(0, 3));
    else if (r < 75)
      hop = TIME_BITS'(delay_cfg >> 1) + TIME_BITS'($urandom_range(0, delay_cfg));
    else if (r < 92)
      hop = TIME_BITS'($urandom_range(0, 1 << 20));
    else if (r < 96)
      hop = TIME_BITS'($urandom);
    else
      hop = '0;
    if (r >= 96) begin
      hop = TIME_BITS'($urandom_range(0, 5000));
      t_cur = (t_cur > hop) ? t_cur - hop : '0;
    end else begin
      sum = {1'b0, t_cur} + {1'b0, hop};
      t_cur = sum[TIME_BITS] ? TOP_TIME : sum[TIME_BITS-1:0];
    end
    return t_cur;
  endfunction

  // one recovery episode: request, polls with the odd failure, then success (always when clean)
  task automatic add_episode(int top_polls, bit clean);
    repeat ($urandom_range(1, top_polls)) begin
      if (n_queued < 0) break;
    end
    queue_event(CMD_REQUEST, step_time());
    repeat ($urandom_range(1, top_polls)) begin
      if ($urandom_range(0, 3) == 0)
        queue_event(CMD_FAILED, step_time());
      queue_event(CMD_POLL, step_time());
    end
    if (clean || $urandom_range(0, 99) < 88)
      queue_event(CMD_SUCCEEDED, step_time());
  endtask

  // stray events of any kind, a few at absolute random times
  task automatic add_noise();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 9) == 0)
        queue_event(cmd_t'($urandom_range(0, 3)), TIME_BITS'({$urandom, $urandom}));
      else
        queue_event(cmd_t'($urandom_range(0, 3)), step_time());
    end
  endtask

  // a random phase; opens with a success so no leftover tries carry over
  task automatic run_phase(int count, int top_polls, bit clean);
    int stop;
    stop = n_queued + count;
    queue_event(CMD_SUCCEEDED, t_cur);
    while (n_queued < stop) begin
      if (clean || $urandom_range(0, 99) < 80)
        add_episode(top_polls, clean);
      else
        add_noise();
    end
  endtask

  // wait until every queued event has given its result
  task automatic wait_idle();
    while (n_outcomes < n_queued) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_TRIES)
      ceil_cfg = val[TRIES_BITS-1:0];
    else
      delay_cfg = val[DELAY_BITS-1:0];
  endtask

  // run limit
  initial begin
    #400000;
    $display("bounded_retry_pacer_tb: FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle poll, failure while idle, arming, attempts,
    // early poll, time going backwards, ceiling reached without a poll
    queue_event(CMD_POLL, 48'd5);
    queue_event(CMD_FAILED, 48'd10);
    queue_event(CMD_SUCCEEDED, 48'd12);
    queue_event(CMD_REQUEST, 48'd20);
    queue_event(CMD_REQUEST, 48'd25);
    queue_event(CMD_POLL, 48'd30);
    queue_event(CMD_POLL, 48'd500);
    queue_event(CMD_FAILED, 48'd600);
    queue_event(CMD_POLL, 48'd1600);
    queue_event(CMD_POLL, 48'd100);
    queue_event(CMD_POLL, 48'd2600);
    queue_event(CMD_FAILED, 48'd2700);
    queue_event(CMD_SUCCEEDED, 48'd2800);
    wait_idle();

    // largest delay at the top of the time range: sums saturate
    set_reg(REG_MAX_TRIES, 32'd255);
    set_reg(REG_BACKOFF, 32'hFFFF_FFFF);
    queue_event(CMD_REQUEST, TOP_TIME - 48'd10);
    queue_event(CMD_POLL, TOP_TIME - 48'd10);
    queue_event(CMD_FAILED, TOP_TIME);
    queue_event(CMD_POLL, TOP_TIME);
    queue_event(CMD_SUCCEEDED, TOP_TIME);
    wait_idle();

    // zero delay: every poll at the same time is an attempt
    set_reg(REG_BACKOFF, 32'd0);
    queue_event(CMD_REQUEST, 48'd0);
    queue_event(CMD_POLL, 48'd0);
    queue_event(CMD_POLL, 48'd0);
    queue_event(CMD_SUCCEEDED, 48'd0);
    wait_idle();

    // random, zero delay; the receiver holds off for long once while events wait in the queue
    t_cur = TIME_BITS'({$urandom, $urandom}) >> 2;
    run_phase(280, 8, 1'b0);
    want_choke <= 1'b1;
    wait_idle();

    // random, moderate delay, no idling on either side
    set_reg(REG_MAX_TRIES, 32'd200);
    set_reg(REG_BACKOFF, $urandom_range(1, 5000));
    t_cur = TIME_BITS'({$urandom, $urandom});
    calm <= 1'b1;
    run_phase(280, 8, 1'b0);
    wait_idle();
    calm <= 1'b0;

    // random, largest delay near the top of time
    set_reg(REG_MAX_TRIES, 32'd255);
    set_reg(REG_BACKOFF, 32'hFFFF_FFFF);
    t_cur = TOP_TIME - TIME_BITS'($urandom);
    run_phase(280, 8, 1'b0);
    wait_idle();

    // random, delay anywhere in its range
    set_reg(REG_MAX_TRIES, 32'd230);
    set_reg(REG_BACKOFF, $urandom);
    t_cur = TIME_BITS'({$urandom, $urandom}) >> 4;
    run_phase(280, 8, 1'b0);
    wait_idle();

    // small ceiling, clean episodes: the ceiling can be reached but is never
    // exceeded, and once it is reached the wake time follows the event time
    set_reg(REG_MAX_TRIES, 32'd4);
    set_reg(REG_BACKOFF, $urandom_range(100, 2000));
    t_cur = TIME_BITS'($urandom);
    run_phase(250, 4, 1'b1);
    wait_idle();

    // zero ceiling: first poll gives up for good, requests are then ignored
    set_reg(REG_MAX_TRIES, 32'd0);
    queue_event(CMD_REQUEST, t_cur);
    queue_event(CMD_FAILED, t_cur);
    queue_event(CMD_POLL, t_cur);
    queue_event(CMD_REQUEST, t_cur + 48'd1);
    queue_event(CMD_SUCCEEDED, t_cur + 48'd2);
    queue_event(CMD_POLL, t_cur + 48'd3);
    wait_idle();

    // events after giving up
    set_reg(REG_MAX_TRIES, $urandom_range(0, 255));
    repeat (30) add_noise();
    wait_idle();
    repeat (8) @(posedge clk);

    if (outcome_q.size() != 0) begin
      n_bad++;
      $display("%0d expected results never arrived", outcome_q.size());
    end
    $display("covered %0d events with %0d results checked: %0d holds, %0d attempts, %0d gave up",
             n_queued, n_outcomes, n_hold, n_attempt, n_exhaust);
    $display("ceilings 0 to 255, delays 0 to full range, saturated times; %0d mismatches",
             n_bad);
    if (n_bad == 0) begin
      $display("bounded_retry_pacer_tb: PASS");
    end else begin
      $display("bounded_retry_pacer_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
